[rtl/rgb_linear_fade_engine_defines.svh]
// ============================================================================
// rgb_linear_fade_engine_defines.svh
// Assertion macros for the fade engine; they compile to nothing in synthesis.
// ============================================================================
`ifndef RGB_LINEAR_FADE_ENGINE_DEFINES_SVH
`define RGB_LINEAR_FADE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// condition implies property in the same cycle
`define RLF_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rlf assertion failed");
// condition implies property in the following cycle
`define RLF_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rlf assertion failed");
`else
`define RLF_ASSERT_IMP(lbl, cond, prop)
`define RLF_ASSERT_NXT(lbl, cond, prop)
`endif

`endif

[rtl/rlf_pkg.sv]
// ============================================================================
// rlf_pkg
// Shared types and constants of the RGB linear fade engine.
// ============================================================================
package rlf_pkg;

    localparam int COL_W     = 16;
    localparam int TIME_W    = 24;
    localparam int ELAPSED_W = 16;
    localparam int NCH       = 3;

    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_ADV   = 2'd2;

    typedef enum logic [1:0] {
        OP_SET,
        OP_START,
        OP_ADV,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [COL_W-1:0]     red;
        logic [COL_W-1:0]     green;
        logic [COL_W-1:0]     blue;
        logic [TIME_W-1:0]    delay;
        logic [TIME_W-1:0]    dur;
        logic [ELAPSED_W-1:0] elapsed;
    } cmd_t;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_TICK,
        ST_MUL,
        ST_ADD,
        ST_RESP
    } state_t;

endpackage

[rtl/rlf_intf.sv]
// ============================================================================
// rlf_intf
// Valid/ready channels of the fade engine: command beats in, result beats out.
// ============================================================================
interface rlf_cmd_if
    import rlf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [COL_W-1:0]     red_in;
    logic [COL_W-1:0]     green_in;
    logic [COL_W-1:0]     blue_in;
    logic [TIME_W-1:0]    delay_ticks;
    logic [TIME_W-1:0]    duration_ticks;
    logic [ELAPSED_W-1:0] elapsed_ticks;

    modport source (
        output valid, func, red_in, green_in, blue_in,
               delay_ticks, duration_ticks, elapsed_ticks,
        input  ready
    );
    modport sink (
        input  valid, func, red_in, green_in, blue_in,
               delay_ticks, duration_ticks, elapsed_ticks,
        output ready
    );
endinterface

interface rlf_rsp_if
    import rlf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic             fading;
    logic [COL_W-1:0] red_out;
    logic [COL_W-1:0] green_out;
    logic [COL_W-1:0] blue_out;

    modport source (
        output valid, accepted, fading, red_out, green_out, blue_out,
        input  ready
    );
    modport sink (
        input  valid, accepted, fading, red_out, green_out, blue_out,
        output ready
    );
endinterface

[rtl/rlf_fifo.sv]
// ============================================================================
// rlf_fifo
// Short command queue between the front decode stage and the execution unit.
// ============================================================================
module rlf_fifo
    import rlf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t data_in,
    output logic full,
    input  logic pop,
    output cmd_t data_out,
    output logic empty
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

[rtl/rlf_front.sv]
// ============================================================================
// rlf_front
// Command intake: decodes func, masks colour and time fields to the configured widths.
// ============================================================================
module rlf_front
    import rlf_pkg::*;
#(
    parameter int TIME_BITS   = 24,
    parameter int COLOUR_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    rlf_cmd_if.sink       cmd,
    input  logic          q_full,
    output logic          q_push,
    output cmd_t          q_data
);

    localparam int TE = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

    logic vld_reg;
    logic vld_next;
    cmd_t data_reg;
    cmd_t data_next;
    logic take;

    assign q_push    = vld_reg && !q_full;
    assign q_data    = data_reg;
    assign cmd.ready = !vld_reg || !q_full;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        data_next         = data_reg;
        data_next.red     = COL_W'(cmd.red_in[COLOUR_BITS-1:0]);
        data_next.green   = COL_W'(cmd.green_in[COLOUR_BITS-1:0]);
        data_next.blue    = COL_W'(cmd.blue_in[COLOUR_BITS-1:0]);
        data_next.delay   = TIME_W'(cmd.delay_ticks[TE-1:0]);
        data_next.dur     = TIME_W'(cmd.duration_ticks[TE-1:0]);
        data_next.elapsed = cmd.elapsed_ticks;
        case (cmd.func)
            FUNC_SET:   data_next.op = OP_SET;
            FUNC_START: data_next.op = OP_START;
            FUNC_ADV:   data_next.op = OP_ADV;
            default:    data_next.op = OP_NOP;
        endcase

        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (q_push)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/rlf_div.sv]
// ============================================================================
// rlf_div
// Three-lane restoring divider, one quotient bit per lane per cycle.
// ============================================================================
module rlf_div
    import rlf_pkg::*;
#(
    parameter int DW = 32,
    parameter int VW = 24
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend [NCH],
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot [NCH]
);

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [VW-1:0] dvs_reg;
    logic [VW-1:0] rem_reg  [NCH];
    logic [VW-1:0] rem_next [NCH];
    logic [DW-1:0] q_reg    [NCH];
    logic [DW-1:0] q_next   [NCH];
    logic [VW:0]   rem_sh   [NCH];
    logic [VW:0]   rem_sub  [NCH];

    assign done = done_reg;
    assign quot = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        for (int c = 0; c < NCH; c++)
        begin
            rem_sh[c]   = {rem_reg[c], q_reg[c][DW-1]};
            rem_sub[c]  = rem_sh[c] - {1'b0, dvs_reg};
            rem_next[c] = rem_reg[c];
            q_next[c]   = q_reg[c];
            if (start)
            begin
                rem_next[c] = '0;
                q_next[c]   = dividend[c];
            end
            else if (busy_reg)
            begin
                // remainder stays below the divisor, so VW bits hold it
                if (rem_sh[c] >= {1'b0, dvs_reg})
                begin
                    rem_next[c] = rem_sub[c][VW-1:0];
                    q_next[c]   = {q_reg[c][DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = rem_sh[c][VW-1:0];
                    q_next[c]   = {q_reg[c][DW-2:0], 1'b0};
                end
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

endmodule

[rtl/rlf_back.sv]
// ============================================================================
// rlf_back
// Execution unit: holds the fade state, runs each command and registers the
// result beat.
// ============================================================================
module rlf_back
    import rlf_pkg::*;
#(
    parameter int TIME_BITS      = 24,
    parameter int COLOUR_BITS    = 16,
    parameter int STEP_FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cmd_t      q_data,
    output logic      q_pop,
    rlf_rsp_if.source rsp
);

    localparam int AW = COLOUR_BITS + STEP_FRAC_BITS;
    localparam int TE = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam int TW = ((TE > ELAPSED_W) ? TE : ELAPSED_W) + 2;
    localparam int PW = AW + ELAPSED_W + 2;
    localparam logic [AW-1:0] ACC_MAX = {AW{1'b1}};

    state_t                   state_reg;
    state_t                   state_next;
    cmd_t                     cmd_reg;
    cmd_t                     cmd_next;
    logic [AW-1:0]            acc_reg   [NCH];
    logic [AW-1:0]            acc_next  [NCH];
    logic signed [AW:0]       step_reg  [NCH];
    logic signed [AW:0]       step_next [NCH];
    logic [COLOUR_BITS-1:0]   tgt_reg   [NCH];
    logic [COLOUR_BITS-1:0]   tgt_next  [NCH];
    logic [NCH-1:0]           neg_reg;
    logic [NCH-1:0]           neg_next;
    logic signed [TW-1:0]     timer_reg;
    logic signed [TW-1:0]     timer_next;
    logic signed [TW-1:0]     old_t_reg;
    logic signed [TW-1:0]     old_t_next;
    logic [TE-1:0]            len_reg;
    logic [TE-1:0]            len_next;
    logic                     active_reg;
    logic                     active_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic [ELAPSED_W-1:0]     ticks_reg;
    logic [ELAPSED_W-1:0]     ticks_next;
    logic                     fin_reg;
    logic                     fin_next;
    logic [1:0]               ch_reg;
    logic [1:0]               ch_next;
    logic signed [PW-1:0]     prod_reg;
    logic signed [PW-1:0]     prod_next;
    logic                     out_vld_reg;
    logic                     out_vld_next;
    logic                     out_acc_reg;
    logic                     out_acc_next;
    logic                     out_fad_reg;
    logic                     out_fad_next;
    logic [COL_W-1:0]         out_col_reg  [NCH];
    logic [COL_W-1:0]         out_col_next [NCH];

    logic [COLOUR_BITS-1:0]   rgb   [NCH];
    logic [COLOUR_BITS-1:0]   shown [NCH];
    logic signed [AW:0]       delta [NCH];
    logic signed [AW:0]       ndelta[NCH];
    logic [AW-1:0]            mag   [NCH];
    logic                     same;
    logic                     dur_nz;
    logic                     div_start;
    logic                     div_done;
    logic [AW-1:0]            quot  [NCH];
    logic signed [PW-1:0]     mul_out;
    logic signed [PW-1:0]     sum;
    logic signed [TW-1:0]     len_s;
    logic signed [TW-1:0]     lo;
    logic signed [TW-1:0]     hi;
    logic signed [TW-1:0]     span;

    assign rgb[0] = cmd_reg.red[COLOUR_BITS-1:0];
    assign rgb[1] = cmd_reg.green[COLOUR_BITS-1:0];
    assign rgb[2] = cmd_reg.blue[COLOUR_BITS-1:0];

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign dur_nz    = (cmd_reg.dur[TE-1:0] != '0);
    assign div_start = (state_reg == ST_EXEC) && (cmd_reg.op == OP_START) && dur_nz && !same;

    always_comb
    begin
        same = 1'b1;
        for (int c = 0; c < NCH; c++)
        begin
            shown[c]  = acc_reg[c][AW-1:STEP_FRAC_BITS];
            delta[c]  = $signed({1'b0, rgb[c], {STEP_FRAC_BITS{1'b0}}})
                        - $signed({1'b0, acc_reg[c]});
            ndelta[c] = -delta[c];
            mag[c]    = delta[c][AW] ? ndelta[c][AW-1:0] : delta[c][AW-1:0];
            if (rgb[c] != shown[c])
            begin
                same = 1'b0;
            end
        end
    end

    rlf_div #(
        .DW (AW),
        .VW (TE)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (cmd_reg.dur[TE-1:0]),
        .done     (div_done),
        .quot     (quot)
    );

    // step * ticks for the channel in turn, then accumulate with clamp
    assign mul_out = step_reg[ch_reg] * $signed({1'b0, ticks_reg});
    assign sum     = prod_reg + $signed(PW'(acc_reg[ch_reg]));

    assign len_s = $signed(TW'(len_reg));
    assign lo    = (old_t_reg > 0) ? old_t_reg : '0;
    assign hi    = (timer_reg < len_s) ? timer_reg : len_s;
    assign span  = hi - lo;

    assign rsp.valid     = out_vld_reg;
    assign rsp.accepted  = out_acc_reg;
    assign rsp.fading    = out_fad_reg;
    assign rsp.red_out   = out_col_reg[0];
    assign rsp.green_out = out_col_reg[1];
    assign rsp.blue_out  = out_col_reg[2];

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        acc_next     = acc_reg;
        step_next    = step_reg;
        tgt_next     = tgt_reg;
        neg_next     = neg_reg;
        timer_next   = timer_reg;
        old_t_next   = old_t_reg;
        len_next     = len_reg;
        active_next  = active_reg;
        hit_next     = hit_reg;
        ticks_next   = ticks_reg;
        fin_next     = fin_reg;
        ch_next      = ch_reg;
        prod_next    = prod_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        out_acc_next = out_acc_reg;
        out_fad_next = out_fad_reg;
        out_col_next = out_col_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next   = q_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                hit_next   = 1'b0;
                state_next = ST_RESP;
                case (cmd_reg.op)
                    OP_SET:
                    begin
                        for (int c = 0; c < NCH; c++)
                        begin
                            acc_next[c] = {rgb[c], {STEP_FRAC_BITS{1'b0}}};
                        end
                        timer_next  = '0;
                        len_next    = '0;
                        active_next = 1'b0;
                        hit_next    = 1'b1;
                    end
                    OP_START:
                    begin
                        if (dur_nz && !same)
                        begin
                            for (int c = 0; c < NCH; c++)
                            begin
                                neg_next[c] = delta[c][AW];
                                tgt_next[c] = rgb[c];
                            end
                            state_next = ST_DIV;
                        end
                    end
                    OP_ADV:
                    begin
                        if (active_reg)
                        begin
                            hit_next   = 1'b1;
                            old_t_next = timer_reg;
                            timer_next = timer_reg + $signed(TW'(cmd_reg.elapsed));
                            state_next = ST_TICK;
                        end
                    end
                    default:
                    begin
                        hit_next = 1'b0;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    for (int c = 0; c < NCH; c++)
                    begin
                        step_next[c] = neg_reg[c] ? -$signed({1'b0, quot[c]})
                                                  : $signed({1'b0, quot[c]});
                    end
                    timer_next  = -$signed(TW'(cmd_reg.delay[TE-1:0]));
                    len_next    = cmd_reg.dur[TE-1:0];
                    active_next = 1'b1;
                    hit_next    = 1'b1;
                    state_next  = ST_RESP;
                end
            end
            ST_TICK:
            begin
                // only the part of the step inside [0, length] moves the colour
                ticks_next = (hi > lo) ? span[ELAPSED_W-1:0] : '0;
                fin_next   = (timer_reg >= len_s);
                ch_next    = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = mul_out;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (sum < 0)
                begin
                    acc_next[ch_reg] = '0;
                end
                else if (sum > $signed(PW'(ACC_MAX)))
                begin
                    acc_next[ch_reg] = ACC_MAX;
                end
                else
                begin
                    acc_next[ch_reg] = sum[AW-1:0];
                end
                if (ch_reg == 2'(NCH - 1))
                begin
                    if (fin_reg)
                    begin
                        for (int c = 0; c < NCH; c++)
                        begin
                            acc_next[c] = {tgt_reg[c], {STEP_FRAC_BITS{1'b0}}};
                        end
                        active_next = 1'b0;
                    end
                    state_next = ST_RESP;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_RESP:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next = 1'b1;
                    out_acc_next = hit_reg;
                    out_fad_next = active_reg;
                    for (int c = 0; c < NCH; c++)
                    begin
                        out_col_next[c] = COL_W'(shown[c]);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            active_reg  <= 1'b0;
            timer_reg   <= '0;
            len_reg     <= '0;
            for (int c = 0; c < NCH; c++)
            begin
                acc_reg[c]  <= '0;
                step_reg[c] <= '0;
                tgt_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            active_reg  <= active_next;
            timer_reg   <= timer_next;
            len_reg     <= len_next;
            acc_reg     <= acc_next;
            step_reg    <= step_next;
            tgt_reg     <= tgt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        neg_reg     <= neg_next;
        old_t_reg   <= old_t_next;
        hit_reg     <= hit_next;
        ticks_reg   <= ticks_next;
        fin_reg     <= fin_next;
        ch_reg      <= ch_next;
        prod_reg    <= prod_next;
        out_acc_reg <= out_acc_next;
        out_fad_reg <= out_fad_next;
        out_col_reg <= out_col_next;
    end

endmodule

[rtl/rgb_linear_fade_engine.sv]
// ============================================================================
// rgb_linear_fade_engine
// Three-channel linear color fader with delayed start and snap to target.
// ============================================================================
// Usage:
//   cmd: valid/ready command beats (set color, start fade, advance time).
//   rsp: valid/ready result beats, exactly one per command, in order.
//   A front stage registers and decodes each command into a two-entry
//   queue; the execution unit drains it one command at a time.
//   Execution in the back end, per command:
//     set color / refused / idle advance / unused code : decode and result only
//     advance of a running fade          : tick setup, then 3 shared mul/add passes
//     accepted start fade                 : waits for the bit-serial step divider
//   Each cmd beat is registered in the front stage and then in the queue
//   before the execution unit takes it. The execution unit takes the next
//   command only once it has registered the result of the last one.
//   Reset clears color, steps, target and timer to zero and leaves the
//   fader idle; rsp.valid drops.
//   If rsp stalls, the result register holds; the execution unit finishes
//   the next command and the queue keeps taking beats until it is full.
// ============================================================================
`include "rgb_linear_fade_engine_defines.svh"

module rgb_linear_fade_engine
    import rlf_pkg::*;
#(
    parameter int TIME_BITS      = 24,
    parameter int COLOUR_BITS    = 16,
    parameter int STEP_FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    rlf_cmd_if.sink   cmd,
    rlf_rsp_if.source rsp
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_in;
    cmd_t q_out;

    rlf_front #(
        .TIME_BITS   (TIME_BITS),
        .COLOUR_BITS (COLOUR_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    rlf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_out),
        .empty    (q_empty)
    );

    rlf_back #(
        .TIME_BITS      (TIME_BITS),
        .COLOUR_BITS    (COLOUR_BITS),
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

    `RLF_ASSERT_IMP(a_push_not_full, q_push, !q_full)
    `RLF_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty)
    `RLF_ASSERT_NXT(a_one_at_a_time, q_pop, !q_pop)

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: RGB linear fade engine testbench
// Drives set-color, start-fade, advance and no-operation beats through the command channel,
// predicts every result beat with a cycle-free model of the fader, and
// compares each result beat field by field under varying idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import rlf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_W         = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_ITEMS    = 175;
    localparam int NUM_PHASES     = 4;
    localparam longint ACC_FULL   = (64'd1 << (COL_W + FRAC_W)) - 1;
    // code the block decodes as no operation
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]           func;
        logic [COL_W-1:0]     red;
        logic [COL_W-1:0]     green;
        logic [COL_W-1:0]     blue;
        logic [TIME_W-1:0]    delay;
        logic [TIME_W-1:0]    dur;
        logic [ELAPSED_W-1:0] elapsed;
    } fade_cmd_t;

    typedef struct packed {
        logic             accepted;
        logic             fading;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } fade_view_t;

    logic clk;
    logic rst_n;

    rlf_cmd_if cmd_ch ();
    rlf_rsp_if rsp_ch ();

    rgb_linear_fade_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    fade_cmd_t  pending_cmds[$];
    fade_view_t expected_views[$];
    fade_cmd_t  next_cmd;
    fade_cmd_t  seen_cmd;
    fade_view_t want_view;
    fade_view_t got_view;

    int  src_idle_pct;
    int  snk_stall_pct;
    int  items_queued;
    int  mismatch_count;
    int  idle_cycles;
    logic cmd_beat;

    // fader state mirrored in the predictor
    longint           color_acc[NCH];
    longint           color_step[NCH];
    logic [COL_W-1:0] fade_target[NCH];
    longint           fade_clock;
    longint           fade_span;
    bit               fade_on;

    function automatic fade_view_t predict_fade(fade_cmd_t c);
        fade_view_t       v;
        logic [COL_W-1:0] rgb[NCH];
        longint           delta;
        longint           mag;
        longint           quot;
        longint           t_old;
        longint           t_new;
        longint           lo;
        longint           hi;
        longint           nv;
        bit               same;
        v = '0;
        rgb[0] = c.red;
        rgb[1] = c.green;
        rgb[2] = c.blue;
        case (c.func)
            FUNC_SET:
            begin
                for (int i = 0; i < NCH; i++)
                    color_acc[i] = longint'(rgb[i]) << FRAC_W;
                fade_clock = 0;
                fade_span  = 0;
                fade_on    = 1'b0;
                v.accepted = 1'b1;
            end
            FUNC_START:
            begin
                same = 1'b1;
                for (int i = 0; i < NCH; i++)
                    if (rgb[i] != color_acc[i][FRAC_W +: COL_W])
                        same = 1'b0;
                if (c.dur != 0 && !same)
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        delta = (longint'(rgb[i]) << FRAC_W) - color_acc[i];
                        mag   = (delta < 0) ? -delta : delta;
                        quot  = mag / longint'(c.dur);
                        color_step[i]  = (delta < 0) ? -quot : quot;
                        fade_target[i] = rgb[i];
                    end
                    fade_clock = -longint'(c.delay);
                    fade_span  = longint'(c.dur);
                    fade_on    = 1'b1;
                    v.accepted = 1'b1;
                end
            end
            FUNC_ADV:
            begin
                if (fade_on)
                begin
                    t_old = fade_clock;
                    t_new = t_old + longint'(c.elapsed);
                    lo = (t_old > 0) ? t_old : 0;
                    hi = (t_new < fade_span) ? t_new : fade_span;
                    v.accepted = 1'b1;
                    fade_clock = t_new;
                    // only ticks inside the fade window move the color
                    if (hi > lo)
                    begin
                        for (int i = 0; i < NCH; i++)
                        begin
                            nv = color_acc[i] + color_step[i] * (hi - lo);
                            if (nv < 0)
                                nv = 0;
                            if (nv > ACC_FULL)
                                nv = ACC_FULL;
                            color_acc[i] = nv;
                        end
                    end
                    if (t_new >= fade_span)
                    begin
                        for (int i = 0; i < NCH; i++)
                            color_acc[i] = longint'(fade_target[i]) << FRAC_W;
                        fade_on = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        v.fading = fade_on;
        v.red    = color_acc[0][FRAC_W +: COL_W];
        v.green  = color_acc[1][FRAC_W +: COL_W];
        v.blue   = color_acc[2][FRAC_W +: COL_W];
        return v;
    endfunction

    task automatic check_field(input string name, input logic [COL_W-1:0] want,
                               input logic [COL_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $realtime, name, want, got);
        end
    endtask

    task automatic push_cmd(input logic [1:0] f, input logic [COL_W-1:0] r,
                            input logic [COL_W-1:0] g, input logic [COL_W-1:0] b,
                            input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] n,
                            input logic [ELAPSED_W-1:0] e);
        fade_cmd_t c;
        c.func    = f;
        c.red     = r;
        c.green   = g;
        c.blue    = b;
        c.delay   = d;
        c.dur     = n;
        c.elapsed = e;
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    function automatic logic [COL_W-1:0] rnd_col();
        return COL_W'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] rnd_time();
        return TIME_W'($urandom);
    endfunction

    function automatic logic [ELAPSED_W-1:0] rnd_tick();
        return ELAPSED_W'($urandom);
    endfunction

    function automatic logic [COL_W-1:0] rand_color();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return '0;
        else if (p < 20)
            return '1;
        return COL_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [ELAPSED_W-1:0] rand_elapsed();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return ELAPSED_W'($urandom_range(0, 40));
        else if (p < 90)
            return ELAPSED_W'($urandom_range(0, 2000));
        return ELAPSED_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // don't-care fields get random values so every input bit toggles
    task automatic push_noise();
        push_cmd(2'($urandom_range(0, 3)), rnd_col(), rnd_col(), rnd_col(),
                 rnd_time(), rnd_time(), rnd_tick());
    endtask

    task automatic queue_fade_run();
        logic [COL_W-1:0]  r;
        logic [COL_W-1:0]  g;
        logic [COL_W-1:0]  b;
        logic [TIME_W-1:0] d;
        logic [TIME_W-1:0] n;
        int                p;
        int                steps;
        r = rand_color();
        g = rand_color();
        b = rand_color();
        p = $urandom_range(0, 99);
        if (p < 10)
        begin
            // start toward the color just loaded: must be refused
            push_cmd(FUNC_SET, r, g, b, rnd_time(), rnd_time(), rnd_tick());
            push_cmd(FUNC_START, r, g, b, rnd_time(), TIME_W'($urandom_range(1, 500)),
                     rnd_tick());
        end
        else if (p < 50)
            push_cmd(FUNC_SET, r, g, b, rnd_time(), rnd_time(), rnd_tick());
        p = $urandom_range(0, 99);
        if (p < 20)
            d = '0;
        else if (p < 90)
            d = TIME_W'($urandom_range(0, 64));
        else
            d = TIME_W'($urandom_range(0, 24'hFFFFFF));
        p = $urandom_range(0, 99);
        if (p < 10)
            n = TIME_W'(1);
        else if (p < 60)
            n = TIME_W'($urandom_range(2, 64));
        else if (p < 90)
            n = TIME_W'($urandom_range(65, 5000));
        else
            n = TIME_W'($urandom_range(1, 24'hFFFFFF));
        push_cmd(FUNC_START, rand_color(), rand_color(), rand_color(), d, n, rnd_tick());
        steps = $urandom_range(1, 8);
        for (int k = 0; k < steps; k++)
            push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(),
                     rand_elapsed());
    endtask

    task automatic queue_directed();
        push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(), 16'hFFFF);
        push_cmd(FUNC_START, 16'h0, 16'h0, 16'h0, rnd_time(), 24'd100, rnd_tick());
        push_cmd(FUNC_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, rnd_time(), 24'd0, rnd_tick());
        push_cmd(FUNC_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF, rnd_time(), rnd_time(), rnd_tick());
        push_cmd(FUNC_START, 16'h0, 16'h0, 16'h0, 24'd0, 24'd1, rnd_tick());
        push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(), 16'd0);
        push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(), 16'hFFFF);
        push_cmd(FUNC_SET, 16'h1234, 16'hABCD, 16'h8000, rnd_time(), rnd_time(), rnd_tick());
        push_cmd(FUNC_START, 16'hFFFF, 16'h0, 16'h8000, 24'hFFFFFF, 24'hFFFFFF, rnd_tick());
        push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(), 16'hFFFF);
        // starts while a fade is pending: zero duration and same color are refused, the last is taken
        push_cmd(FUNC_START, 16'h0, 16'h0, 16'h0, rnd_time(), 24'd0, rnd_tick());
        push_cmd(FUNC_START, 16'h1234, 16'hABCD, 16'h8000, rnd_time(), 24'd10, rnd_tick());
        push_cmd(FUNC_START, 16'h0, 16'hFFFF, 16'h1, 24'd100, 24'd1000, rnd_tick());
        push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(), 16'd50);
        push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(), 16'd100);
        push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(), 16'd500);
        push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(), 16'd1000);
        push_cmd(FUNC_NONE, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(),
                 rnd_tick());
        push_cmd(FUNC_SET, 16'h0, 16'h0, 16'h0, rnd_time(), rnd_time(), rnd_tick());
        push_cmd(FUNC_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0, 24'd3, rnd_tick());
        for (int k = 0; k < 3; k++)
            push_cmd(FUNC_ADV, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(),
                     16'd1);
        push_cmd(FUNC_NONE, rnd_col(), rnd_col(), rnd_col(), rnd_time(), rnd_time(),
                 rnd_tick());
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // command driver and result-side ready, both moved on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_ch.valid || cmd_beat)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    next_cmd = pending_cmds.pop_front();
                    cmd_ch.func           <= next_cmd.func;
                    cmd_ch.red_in         <= next_cmd.red;
                    cmd_ch.green_in       <= next_cmd.green;
                    cmd_ch.blue_in        <= next_cmd.blue;
                    cmd_ch.delay_ticks    <= next_cmd.delay;
                    cmd_ch.duration_ticks <= next_cmd.dur;
                    cmd_ch.elapsed_ticks  <= next_cmd.elapsed;
                    cmd_ch.valid          <= 1'b1;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // monitor: predicts on each command beat, checks each result beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_beat    <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            cmd_beat <= cmd_ch.valid && cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen_cmd.func    = cmd_ch.func;
                seen_cmd.red     = cmd_ch.red_in;
                seen_cmd.green   = cmd_ch.green_in;
                seen_cmd.blue    = cmd_ch.blue_in;
                seen_cmd.delay   = cmd_ch.delay_ticks;
                seen_cmd.dur     = cmd_ch.duration_ticks;
                seen_cmd.elapsed = cmd_ch.elapsed_ticks;
                expected_views.push_back(predict_fade(seen_cmd));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_view.accepted = rsp_ch.accepted;
                got_view.fading   = rsp_ch.fading;
                got_view.red      = rsp_ch.red_out;
                got_view.green    = rsp_ch.green_out;
                got_view.blue     = rsp_ch.blue_out;
                if (expected_views.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, actual 0x%0h",
                             $realtime, got_view);
                end
                else
                begin
                    want_view = expected_views.pop_front();
                    check_field("accepted", COL_W'(want_view.accepted),
                                COL_W'(got_view.accepted));
                    check_field("fading", COL_W'(want_view.fading),
                                COL_W'(got_view.fading));
                    check_field("red_out", want_view.red, got_view.red);
                    check_field("green_out", want_view.green, got_view.green);
                    check_field("blue_out", want_view.blue, got_view.blue);
                end
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no beat for %0d cycles", $realtime,
                         WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int src_mix[NUM_PHASES];
        int snk_mix[NUM_PHASES];
        src_mix = '{0, 54, 0, 24};
        snk_mix = '{0, 0, 54, 24};
        rst_n                 = 1'b0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.func           = FUNC_SET;
        cmd_ch.red_in         = '0;
        cmd_ch.green_in       = '0;
        cmd_ch.blue_in        = '0;
        cmd_ch.delay_ticks    = '0;
        cmd_ch.duration_ticks = '0;
        cmd_ch.elapsed_ticks  = '0;
        rsp_ch.ready          = 1'b0;
        src_idle_pct          = 0;
        snk_stall_pct         = 0;
        items_queued          = 0;
        mismatch_count        = 0;
        fade_clock            = 0;
        fade_span             = 0;
        fade_on               = 1'b0;
        for (int i = 0; i < NCH; i++)
        begin
            color_acc[i]   = 0;
            color_step[i]  = 0;
            fade_target[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            src_idle_pct  = src_mix[ph];
            snk_stall_pct = snk_mix[ph];
            if (ph == 0)
                queue_directed();
            while (items_queued < (ph + 1) * PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 15)
                    push_noise();
                else
                    queue_fade_run();
            end
            while (pending_cmds.size() != 0)
                @(posedge clk);
        end
        while (cmd_ch.valid)
            @(posedge clk);
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
